// File: hw/rtl/mcspg_pkg.sv
// ----------------------------------------------------------------------------
// mcspg_pkg
// Types, register codes and helpers for the multichannel stimulus pulse
// generator.
// ----------------------------------------------------------------------------
package mcspg_pkg;

  // Register map, word index (byte address / 4)
  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_PEAK_AMP  = 3'd1,
    REG_AMP_STEP  = 3'd2,
    REG_PERIOD    = 3'd3,
    REG_END_TIME  = 3'd4,
    REG_RAMP_LEN  = 3'd5
  } reg_idx_t;

  // Input command codes (in_tuser)
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // Output mode codes
  localparam logic MODE_PERIODIC = 1'b0;
  localparam logic MODE_RAMP     = 1'b1;

  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned Q_W        = 31;  // magnitude bits of amp * elapsed
  localparam logic [15:0] ELAPSED_CLIP = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EVAL,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_FIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [31:0]        start;
    logic [31:0]        length;
    logic signed [15:0] amp;
  } entry_t;

  localparam entry_t ENTRY_RST = '{start: 32'hFFFF_FFFF, length: 32'd0, amp: 16'sd0};

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/multi_channel_stimulus_pulse_generator_unit.sv
// ----------------------------------------------------------------------------
// multi_channel_stimulus_pulse_generator_unit
// Per-stream pulse/ramp current generator; stream state held in one memory.
// ----------------------------------------------------------------------------
//  port group  dir  handshake          payload
//  in_         in   tvalid/tready      tuser: cmd; tdata: time, load fields
//  out_        out  tvalid/tready      tdata: stream, current; tlast: last
//  cfg_        in   APB, pready high   6 registers at 4*i
//
//  A load is written into the state memory straight from idle. A tick visits
//  every stream, and one inside its pulse in ramp mode is scaled through
//  a multiply stage and a restoring divider that forms one quotient bit a cycle.
//  Every stream is read and evaluated; one whose pulse is over is written back.
//  A stalled output holds the sequencer in its emit step; the last result of a
//  tick may wait in the output register while the next item is accepted.
//  Reset clears the valid bits; a stream never loaded reads as silent.
// ----------------------------------------------------------------------------
module multi_channel_stimulus_pulse_generator_unit
  import mcspg_pkg::*;
#(
  parameter int N_STREAMS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // now_time[31:0], load_stream[34:32], load_start[66:35], load_length[98:67]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // cmd[0]
  input  logic                  in_tuser,
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // stream_index[2:0], current_out[18:3]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [4:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int IDX_W = (N_STREAMS > 1) ? $clog2(N_STREAMS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_STREAMS - 1);

  // ---------------- configuration registers ----------------
  logic               mode_r;
  logic signed [15:0] peak_amp_r;
  logic signed [15:0] amp_step_r;
  logic [31:0]        period_r;
  logic [31:0]        end_time_r;
  logic [15:0]        ramp_len_r;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_PERIODIC;
      peak_amp_r <= 16'sd0;
      amp_step_r <= 16'sd0;
      period_r   <= 32'd1000;
      end_time_r <= 32'hFFFF_FFFF;
      ramp_len_r <= 16'd100;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        REG_MODE:     mode_r     <= cfg_pwdata[0];
        REG_PEAK_AMP: peak_amp_r <= cfg_pwdata[15:0];
        REG_AMP_STEP: amp_step_r <= cfg_pwdata[15:0];
        REG_PERIOD:   period_r   <= cfg_pwdata;
        REG_END_TIME: end_time_r <= cfg_pwdata;
        REG_RAMP_LEN: ramp_len_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_MODE:     cfg_prdata = {31'd0, mode_r};
      REG_PEAK_AMP: cfg_prdata = {16'd0, peak_amp_r};
      REG_AMP_STEP: cfg_prdata = {16'd0, amp_step_r};
      REG_PERIOD:   cfg_prdata = period_r;
      REG_END_TIME: cfg_prdata = end_time_r;
      REG_RAMP_LEN: cfg_prdata = {16'd0, ramp_len_r};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  // ---------------- input fields ----------------
  logic [31:0] in_now;
  logic [2:0]  in_stream;
  logic [31:0] in_start;
  logic [31:0] in_length;
  logic [6:0]  ld_idx_ext;
  logic        ld_ok;

  assign in_now     = in_tdata[31:0];
  assign in_stream  = in_tdata[34:32];
  assign in_start   = in_tdata[66:35];
  assign in_length  = in_tdata[98:67];
  assign ld_idx_ext = {4'd0, in_stream};
  assign ld_ok      = ld_idx_ext < 7'(N_STREAMS);

  // ---------------- sequencer state ----------------
  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r;
  logic [31:0]        now_r;
  entry_t             rd_ent_r;
  logic               rd_vld_r;
  logic [N_STREAMS-1:0] vld_r;
  logic signed [15:0] cur_r;
  logic [15:0]        el_r;
  logic signed [15:0] amp_r;
  logic signed [31:0] prod_r;
  logic               neg_r;
  logic [Q_W-1:0]     dvd_r;
  logic [15:0]        rem_r;
  logic [15:0]        divisor_r;
  logic [4:0]         cnt_r;

  logic               out_valid_r;
  logic [2:0]         out_idx_r;
  logic signed [15:0] out_cur_r;
  logic               out_last_r;

  // control
  logic   in_acc;
  logic   tick_acc;
  logic   emit_go;
  logic   mem_we;
  logic [IDX_W-1:0] mem_wa;
  entry_t mem_wd;

  // ---------------- evaluate one stream ----------------
  entry_t             ent;
  logic [32:0]        stop;
  logic               live;
  logic               over;
  logic               on;
  logic [32:0]        ns;
  logic signed [16:0] amp_sum;
  logic [31:0]        el_full;
  entry_t             wb_ent;

  assign ent     = rd_vld_r ? rd_ent_r : ENTRY_RST;
  assign stop    = {1'b0, ent.start} + {1'b0, ent.length};
  assign live    = now_r <= end_time_r;
  assign over    = live && ({1'b0, now_r} >= stop);
  assign on      = live && !over && (now_r >= ent.start);
  assign ns      = {1'b0, ent.start} + {1'b0, period_r};
  assign amp_sum = {ent.amp[15], ent.amp} + {amp_step_r[15], amp_step_r};
  assign el_full = now_r - ent.start;

  always_comb begin
    wb_ent        = ent;
    wb_ent.start  = ns[32] ? 32'hFFFF_FFFF : ns[31:0];
    wb_ent.amp    = sat16({{15{amp_sum[16]}}, amp_sum});
  end

  // ---------------- scaling and divider datapath ----------------
  logic signed [32:0] prod_full;
  logic [31:0]        mag;
  logic [16:0]        trial;
  logic               ge;
  logic [16:0]        trial_sub;
  logic [31:0]        qv;
  logic [31:0]        sv;

  assign prod_full = amp_r * $signed({1'b0, el_r});
  assign mag       = prod_r[31] ? 32'(-prod_r) : prod_r;
  assign trial     = {rem_r, dvd_r[Q_W-1]};
  assign ge        = trial >= {1'b0, divisor_r};
  assign trial_sub = trial - {1'b0, divisor_r};
  assign qv        = {1'b0, dvd_r};
  assign sv        = neg_r ? 32'(-qv) : qv;

  // ---------------- control outputs ----------------
  always_comb begin
    in_tready = 1'b0;
    emit_go   = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = idx_r;
    mem_wd    = wb_ent;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && in_tuser == CMD_LOAD && ld_ok) begin
          mem_we = 1'b1;
          mem_wa = ld_idx_ext[IDX_W-1:0];
          mem_wd = '{start: in_start, length: in_length, amp: peak_amp_r};
        end
      end
      ST_EVAL: mem_we  = over;
      ST_EMIT: emit_go = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign in_acc   = in_tvalid && in_tready;
  assign tick_acc = in_acc && (in_tuser == CMD_TICK);

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (tick_acc) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = (on && mode_r == MODE_RAMP) ? ST_MUL : ST_EMIT;
      ST_MUL:  state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == 5'(Q_W - 1)) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_EMIT;
      ST_EMIT: if (emit_go) state_nxt = (idx_r == LAST_IDX) ? ST_IDLE : ST_RD;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (tick_acc) begin
        idx_r <= '0;
      end else if (emit_go && idx_r != LAST_IDX) begin
        idx_r <= idx_r + 1'b1;
      end
      if (mem_we) begin
        vld_r[mem_wa] <= 1'b1;
      end
    end
  end

  // ---------------- state memory ----------------
  entry_t mem [N_STREAMS];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (state_r == ST_RD) begin
      rd_ent_r <= mem[idx_r];
      rd_vld_r <= vld_r[idx_r];
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if (tick_acc) begin
      now_r <= in_now;
    end
    unique case (state_r)
      ST_EVAL: begin
        cur_r <= (on && mode_r == MODE_PERIODIC) ? ent.amp : 16'sd0;
        amp_r <= ent.amp;
        el_r  <= (el_full > {16'd0, ELAPSED_CLIP}) ? ELAPSED_CLIP : el_full[15:0];
      end
      ST_MUL: prod_r <= prod_full[31:0];
      ST_PREP: begin
        neg_r     <= prod_r[31];
        dvd_r     <= mag[Q_W-1:0];
        rem_r     <= 16'd0;
        cnt_r     <= 5'd0;
        divisor_r <= (ramp_len_r == 16'd0) ? 16'd1 : ramp_len_r;
      end
      ST_DIV: begin
        // shift in one quotient bit, keep the partial remainder
        rem_r <= ge ? trial_sub[15:0] : trial[15:0];
        dvd_r <= {dvd_r[Q_W-2:0], ge};
        cnt_r <= cnt_r + 5'd1;
      end
      ST_FIN: cur_r <= sat16(sv);
      default: ;
    endcase
  end

  // ---------------- output register ----------------
  logic [6:0] idx_ext;
  assign idx_ext = 7'(idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_idx_r  <= idx_ext[2:0];
      out_cur_r  <= cur_r;
      out_last_r <= (idx_r == LAST_IDX);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_cur_r, out_idx_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_tick_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    tick_acc |=> (state_r == ST_RD))
    else $error("tick transfer did not start a stream read");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_idx_r == 3'(N_STREAMS - 1)))
    else $error("last flag on a result that is not the final stream");

  a_mem_write_slot: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((state_r == ST_IDLE && in_acc && in_tuser == CMD_LOAD) ||
                (state_r == ST_EVAL && over)))
    else $error("state memory written outside load or write-back");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r < 5'(Q_W)))
    else $error("divider ran past its last step");
`endif

endmodule
